[design/fpog_pkg.sv]
`timescale 1ns / 1ps
// Types and constants shared by the flash program order guard.
// No dependencies; every other file of the block depends on this package.

package fpog_pkg;

  // Field widths of one request beat and one result beat.
  localparam int unsigned KindW   = 1;
  localparam int unsigned OpW     = 3;
  localparam int unsigned RegionW = 2;
  localparam int unsigned StageW  = 3;

  // Item kinds.
  localparam logic [KindW-1:0] KIND_REQUEST = 1'b0;
  localparam logic [KindW-1:0] KIND_WRITE   = 1'b1;

  // Operation codes of a request beat; codes five to seven are undefined.
  typedef enum logic [OpW-1:0] {
    OP_ERASE  = 3'd0,
    OP_MAIN   = 3'd1,
    OP_CCFG   = 3'd2,
    OP_SCFG   = 3'd3,
    OP_REVERT = 3'd4
  } op_e;

  // Region codes of a write-done beat.
  localparam logic [RegionW-1:0] REGION_CCFG  = 2'd0;
  localparam logic [RegionW-1:0] REGION_SCFG  = 2'd1;
  localparam logic [RegionW-1:0] REGION_MAIN  = 2'd2;
  localparam logic [RegionW-1:0] REGION_OTHER = 2'd3;

  // Stage codes as seen on the result port.
  localparam logic [StageW-1:0] STAGE_CODE_INIT   = 3'd0;
  localparam logic [StageW-1:0] STAGE_CODE_ERASED = 3'd1;
  localparam logic [StageW-1:0] STAGE_CODE_CCFG   = 3'd2;
  localparam logic [StageW-1:0] STAGE_CODE_SCFG   = 3'd3;
  localparam logic [StageW-1:0] STAGE_CODE_MAIN   = 3'd4;

  // Internal stage register, one-hot.
  typedef enum logic [4:0] {
    ST_INIT   = 5'b00001,
    ST_ERASED = 5'b00010,
    ST_CCFG   = 5'b00100,
    ST_SCFG   = 5'b01000,
    ST_MAIN   = 5'b10000
  } stage_e;

  // One captured request beat.
  typedef struct packed {
    logic [KindW-1:0]   kind;
    logic [OpW-1:0]     op;
    logic [RegionW-1:0] region;
  } item_t;

  // Maps the one-hot stage to its port code.
  function automatic logic [StageW-1:0] stage_code(input stage_e st);
    logic [StageW-1:0] code;
    unique case (st)
      ST_INIT:   code = STAGE_CODE_INIT;
      ST_ERASED: code = STAGE_CODE_ERASED;
      ST_CCFG:   code = STAGE_CODE_CCFG;
      ST_SCFG:   code = STAGE_CODE_SCFG;
      ST_MAIN:   code = STAGE_CODE_MAIN;
      default:   code = STAGE_CODE_INIT;
    endcase
    return code;
  endfunction

endpackage

[design/fpog_req_if.sv]
`timescale 1ns / 1ps
// Request channel of the flash program order guard: valid, ready and one item.
// Depends on fpog_pkg for the field widths.

interface fpog_req_if;
  logic                          valid;
  logic                          ready;
  logic [fpog_pkg::KindW-1:0]    kind;
  logic [fpog_pkg::OpW-1:0]      op;
  logic [fpog_pkg::RegionW-1:0]  region;

  modport source (output valid, output kind, output op, output region, input ready);
  modport sink   (input valid, input kind, input op, input region, output ready);
endinterface

[design/fpog_res_if.sv]
`timescale 1ns / 1ps
// Result channel of the flash program order guard: valid, ready and one result.
// Depends on fpog_pkg for the field widths.

interface fpog_res_if;
  logic                         valid;
  logic                         ready;
  logic                         allowed;
  logic [fpog_pkg::StageW-1:0]  stage_now;
  logic                         all_done;
  logic                         erase_refused;

  modport source (output valid, output allowed, output stage_now, output all_done,
                  output erase_refused, input ready);
  modport sink   (input valid, input allowed, input stage_now, input all_done,
                  input erase_refused, output ready);
endinterface

[design/fpog_in_stage.sv]
`timescale 1ns / 1ps
// Input register of the flash program order guard.
// Depends on fpog_pkg and fpog_req_if.

module fpog_in_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  fpog_req_if.sink        req_i,
  output fpog_pkg::item_t item_o,
  input  logic            item_ready_i,
  output logic            item_valid_o
);
  import fpog_pkg::*;

  logic  valid_q;
  item_t item_q;
  logic  take;

  // The register empties when the decision stage takes its beat.
  assign req_i.ready = !valid_q || item_ready_i;
  assign take        = req_i.valid && req_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (req_i.ready) begin
      valid_q <= req_i.valid;
    end
  end

  // Payload is captured without reset.
  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= '{kind: req_i.kind, op: req_i.op, region: req_i.region};
    end
  end

  assign item_o       = item_q;
  assign item_valid_o = valid_q;

endmodule

[design/fpog_guard.sv]
`timescale 1ns / 1ps
// Decision stage of the flash program order guard: stage and region marks,
// the transition table and the result register. Depends on fpog_pkg, fpog_res_if.

module fpog_guard (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  fpog_pkg::item_t item_i,
  input  logic            item_valid_i,
  output logic            item_ready_o,
  fpog_res_if.source      res_o
);
  import fpog_pkg::*;

  stage_e stage_q, stage_d;
  logic   ccfg_q, ccfg_d;
  logic   scfg_q, scfg_d;
  logic   main_q, main_d;

  logic              res_valid_q;
  logic              allowed_q, allowed_d;
  logic [StageW-1:0] stage_now_q;
  logic              all_done_q, done_d;
  logic              erase_refused_q, erase_refused_d;

  logic   step;
  logic   ok;
  logic   to_done;
  logic   clear;
  stage_e nxt;
  op_e    op;

  // A beat moves on when the result register is free or being drained.
  assign item_ready_o = !res_valid_q || res_o.ready;
  assign step         = item_valid_i && item_ready_o;
  assign op           = op_e'(item_i.op);

  // Transition table for request beats.
  always_comb begin
    ok      = 1'b0;
    to_done = 1'b0;
    clear   = 1'b0;
    nxt     = stage_q;
    unique case (stage_q)
      ST_INIT: begin
        if (op == OP_ERASE) begin
          ok = 1'b1; nxt = ST_ERASED; clear = 1'b1;
        end else if (op == OP_MAIN) begin
          ok = 1'b1; nxt = ST_MAIN;
        end
      end
      ST_ERASED: begin
        if (op == OP_REVERT) begin
          ok = 1'b1; nxt = ST_INIT;
        end else if (op == OP_CCFG) begin
          ok = 1'b1; nxt = ST_CCFG;
        end else if (op == OP_SCFG) begin
          ok = 1'b1; nxt = ST_SCFG;
        end else if (op == OP_MAIN) begin
          ok = 1'b1; nxt = ST_MAIN;
        end
      end
      ST_CCFG: begin
        if (op == OP_REVERT) begin
          ok = 1'b1; nxt = ST_ERASED; clear = 1'b1;
        end else if (op == OP_MAIN) begin
          ok = 1'b1; nxt = ST_MAIN; to_done = scfg_q;
        end else if (op == OP_SCFG) begin
          ok = 1'b1; nxt = ST_SCFG; to_done = main_q;
        end
      end
      ST_SCFG: begin
        if (op == OP_REVERT) begin
          ok = 1'b1; nxt = ST_ERASED; clear = 1'b1;
        end else if (op == OP_MAIN) begin
          ok = 1'b1; nxt = ST_MAIN; to_done = ccfg_q;
        end else if (op == OP_CCFG) begin
          ok = 1'b1; nxt = ST_CCFG; to_done = main_q;
        end
      end
      ST_MAIN: begin
        if (op == OP_REVERT) begin
          ok = 1'b1; nxt = ST_ERASED; clear = 1'b1;
        end else if (op == OP_CCFG) begin
          ok = 1'b1; nxt = ST_CCFG; to_done = scfg_q;
        end else if (op == OP_SCFG) begin
          ok = 1'b1; nxt = ST_SCFG; to_done = ccfg_q;
        end else if (op == OP_MAIN) begin
          ok = 1'b1; nxt = ST_MAIN; to_done = 1'b1;
        end
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  // Next state and result fields; write-done beats only set a mark.
  always_comb begin
    stage_d         = stage_q;
    ccfg_d          = ccfg_q;
    scfg_d          = scfg_q;
    main_d          = main_q;
    allowed_d       = 1'b0;
    done_d          = 1'b0;
    erase_refused_d = 1'b0;
    if (item_i.kind == KIND_WRITE) begin
      ccfg_d = ccfg_q || (item_i.region == REGION_CCFG);
      scfg_d = scfg_q || (item_i.region == REGION_SCFG);
      main_d = main_q || (item_i.region == REGION_MAIN);
    end else begin
      allowed_d       = ok;
      done_d          = to_done;
      erase_refused_d = (op == OP_ERASE) && !ok;
      stage_d         = to_done ? ST_INIT : nxt;
      if (clear || to_done) begin
        ccfg_d = 1'b0;
        scfg_d = 1'b0;
        main_d = 1'b0;
      end
    end
  end

  // Session state advances once per beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= ST_INIT;
      ccfg_q  <= 1'b0;
      scfg_q  <= 1'b0;
      main_q  <= 1'b0;
    end else if (step) begin
      stage_q <= stage_d;
      ccfg_q  <= ccfg_d;
      scfg_q  <= scfg_d;
      main_q  <= main_d;
    end
  end

  // Result register valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (item_ready_o) begin
      res_valid_q <= item_valid_i;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (step) begin
      allowed_q       <= allowed_d;
      stage_now_q     <= stage_code(stage_d);
      all_done_q      <= done_d;
      erase_refused_q <= erase_refused_d;
    end
  end

  assign res_o.valid         = res_valid_q;
  assign res_o.allowed       = allowed_q;
  assign res_o.stage_now     = stage_now_q;
  assign res_o.all_done      = all_done_q;
  assign res_o.erase_refused = erase_refused_q;

  // A completed session reports itself as allowed and back at init.
  a_done_at_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && all_done_q) |-> (allowed_q && stage_now_q == STAGE_CODE_INIT))
    else $error("completion reported without an allowed return to init");

  // Completion clears every region mark.
  a_done_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && done_d) |=> (!ccfg_q && !scfg_q && !main_q && stage_q == ST_INIT))
    else $error("marks or stage not cleared after completion");

  // A write-done beat never moves the stage.
  a_write_keeps_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && item_i.kind == KIND_WRITE) |=> $stable(stage_q))
    else $error("write-done beat changed the stage");

  // A refused erase is never also allowed.
  a_refused_not_allowed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && erase_refused_q) |-> !allowed_q)
    else $error("erase flagged refused while allowed");

  // The result register only fills from a beat taken the cycle before.
  a_result_from_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_q) |-> $past(step))
    else $error("result appeared without a source beat");

endmodule

[design/flash_program_order_guard.sv]
`timescale 1ns / 1ps
// Top level of the flash program order guard: input register and decision stage.
// Depends on fpog_pkg, fpog_req_if, fpog_res_if, fpog_in_stage and fpog_guard.

// The guard takes one beat per clock cycle on req_i unless res_o stalls, and
// returns exactly one result beat per accepted beat on res_o, each passing the
// input register and then the result register. Throughput is one beat per cycle
// while res_o is not stalled, set by the single decision stage that reads and
// updates the stage and the three region marks together. Request beats are
// answered with allowed or refused against the stage table; write-done beats
// only set their region's mark. Stalls on res_o fill the input register, and
// req_i.ready drops once both registers hold beats while res_o.ready is low.

module flash_program_order_guard (
  input  logic       clk_i,
  input  logic       rst_ni,
  fpog_req_if.sink   req_i,
  fpog_res_if.source res_o
);
  import fpog_pkg::*;

  item_t item;
  logic  item_valid;
  logic  item_ready;

  fpog_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_i),
    .item_o       (item),
    .item_ready_i (item_ready),
    .item_valid_o (item_valid)
  );

  fpog_guard u_guard (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (item),
    .item_valid_i (item_valid),
    .item_ready_o (item_ready),
    .res_o        (res_o)
  );

endmodule
